// File: sv/sil_pkg.sv
// Shared types and constants for the sorted insertion list.
// No dependencies; every other file imports this package.
`default_nettype none

package sil_pkg;

	localparam int DATA_W = 32;

	// Request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [1:0] {
		STAT_INSERTED = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_ENTRY    = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_OUT_RD,
		S_OUT_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: sv/sorted_insertion_list.sv
// Top level of the sorted insertion list: sequencer, fill count and result register.
// Depends on sil_pkg, sil_mem and sil_cmp.
//
// Usage
//   A request is taken on a rising edge with start high and busy low. opcode
//   selects insert (value goes in ascending order, ahead of equal values) or
//   read (the whole list comes out in ascending order).
//   Every result appears on status, entry and last for exactly one cycle with
//   strobe high; the receiver cannot stall it, so it must take each one.
//   Insert: one result, inserted or full. The search walks down from the top
//   of the list; each stored value is read from the store, then compared and
//   shifted in the single compare unit, until the new value finds its place
//   or reaches the bottom of the list; a full list is refused without a search.
//   Read: one result per stored value, each fetched through the single read
//   port of the store; an empty list gives one empty result right away.
//   The result register sits after the sequencer, so the strobe of the final
//   result comes in the first cycle with busy low, and a new request may be
//   taken in that same cycle.
//   Reset clears the fill count and sequencer; the store keeps no reset and
//   is never read above the fill count.
`default_nettype none

module sorted_insertion_list import sil_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     opcode,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          strobe,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      entry,
	output logic                          last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] IDX_ONE = AW'(1);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

	state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] fill_q, fill_d;
	logic signed [DATA_W-1:0] val_q, val_d;

	logic strobe_q, strobe_d;
	status_t status_q, status_d;
	logic signed [DATA_W-1:0] entry_q, entry_d;
	logic last_q, last_d;

	// Store port controls
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic signed [DATA_W-1:0] mem_wdata, mem_rdata;
	logic not_smaller;
	logic take;

	sil_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sil_cmp u_cmp (
		.stored     (mem_rdata),
		.incoming   (val_q),
		.not_smaller(not_smaller)
	);

	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		fill_d    = fill_q;
		val_d     = val_q;
		strobe_d  = 1'b0;
		status_d  = status_q;
		entry_d   = '0;
		last_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = val_q;
		mem_raddr = idx_q;

		case (state_q)
			S_IDLE: begin
				if (take) begin
					val_d = value;
					if (opcode == OP_INSERT) begin
						if (fill_q >= CNT_CAP) begin
							// List full: refuse at once
							strobe_d = 1'b1;
							status_d = STAT_FULL;
							last_d   = 1'b1;
						end else begin
							// Start at the free slot just above the top entry
							idx_d   = fill_q[AW-1:0];
							state_d = (fill_q == '0) ? S_INS_PUT : S_INS_RD;
						end
					end else begin
						if (fill_q == '0) begin
							strobe_d = 1'b1;
							status_d = STAT_EMPTY;
							last_d   = 1'b1;
						end else begin
							idx_d   = '0;
							state_d = S_OUT_RD;
						end
					end
				end
			end

			S_INS_RD: begin
				// Fetch the entry just below the hole
				mem_raddr = idx_q - IDX_ONE;
				state_d   = S_INS_CMP;
			end

			S_INS_CMP: begin
				mem_we = 1'b1;
				if (not_smaller) begin
					// Shift the stored value up into the hole
					mem_wdata = mem_rdata;
					idx_d     = idx_q - IDX_ONE;
					state_d   = (idx_q == IDX_ONE) ? S_INS_PUT : S_INS_RD;
				end else begin
					// Hole found: drop the new value in
					mem_wdata = val_q;
					fill_d    = fill_q + CNT_ONE;
					strobe_d  = 1'b1;
					status_d  = STAT_INSERTED;
					last_d    = 1'b1;
					state_d   = S_IDLE;
				end
			end

			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
				fill_d    = fill_q + CNT_ONE;
				strobe_d  = 1'b1;
				status_d  = STAT_INSERTED;
				last_d    = 1'b1;
				state_d   = S_IDLE;
			end

			S_OUT_RD: begin
				mem_raddr = idx_q;
				state_d   = S_OUT_EMIT;
			end

			S_OUT_EMIT: begin
				strobe_d = 1'b1;
				status_d = STAT_ENTRY;
				entry_d  = mem_rdata;
				if ((CW'(idx_q) + CNT_ONE) == fill_q) begin
					last_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					idx_d   = idx_q + IDX_ONE;
					state_d = S_OUT_RD;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			strobe_q <= strobe_d;
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		val_q    <= val_d;
		status_q <= status_d;
		entry_q  <= entry_d;
		last_q   <= last_d;
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign entry  = entry_q;
	assign last   = last_q;

	// Fill count stays within the list size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_CAP)
		else $error("fill count above capacity");

	// A compare always follows a store read
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP) |-> ($past(state_q) == S_INS_RD))
		else $error("compare without preceding read");

	// Status-only results carry zero entry and close the request
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (status_q != STAT_ENTRY)) |-> ((entry_q == '0) && last_q))
		else $error("status result malformed");

	// An inserted result comes with exactly one more stored entry
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (status_q == STAT_INSERTED)) |->
		(fill_q == ($past(fill_q) + CNT_ONE)))
		else $error("insert did not grow the list");

endmodule

`default_nettype wire

// File: sv/sil_mem.sv
// Value store of the sorted insertion list: one write port, one registered read port.
// Depends on sil_pkg for the data width.
`default_nettype none

module sil_mem import sil_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic signed [DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]            raddr,
	output logic signed [DATA_W-1:0]      rdata
);

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/sil_cmp.sv
// Shared signed compare unit of the sorted insertion list.
// Depends on sil_pkg for the data width.
`default_nettype none

module sil_cmp import sil_pkg::*; (
	input  wire logic signed [DATA_W-1:0] stored,
	input  wire logic signed [DATA_W-1:0] incoming,
	output logic                          not_smaller
);

	// Stored value at or above the new one moves up past it
	assign not_smaller = (stored >= incoming);

endmodule

`default_nettype wire
